/* src/sss_pkg.sv */
// Shared types and fixed field widths for the sample set statistics block.
// Used by sss_accum and sample_set_statistics; depends on nothing else.
package sss_pkg;

  localparam int SAMPLE_W = 16;  // signed input sample
  localparam int SQ_W     = 31;  // square of one sample, unsigned
  localparam int MEAN_W   = 24;  // mean in Q8, two's complement
  localparam int RMS_W    = 24;  // RMS in Q8, unsigned
  localparam int COUNT_W  = 8;   // reported sample count

  // Control from the sequencer to the accumulator.
  typedef struct packed {
    logic load;   // an item is accepted this cycle
    logic clear;  // the result is handed over, start a fresh set
  } acc_ctl_t;

endpackage

/* src/sss_trial_sub.sv */
// Shared compare-and-subtract unit used for every division and root step.
// Depends on nothing; the sequencer in sample_set_statistics drives it.
module sss_trial_sub #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] minuend,
  input  logic [WIDTH-1:0] subtrahend,
  output logic [WIDTH-1:0] diff,
  output logic             ge
);

  logic [WIDTH:0] full;

  assign full = {1'b0, minuend} - {1'b0, subtrahend};
  assign diff = full[WIDTH-1:0];
  assign ge   = !full[WIDTH];

endmodule

/* src/sss_accum.sv */
// Running maximum, minimum, sum, sum of squares and count of one sample set.
// Depends on sss_pkg; instantiated by sample_set_statistics.
module sss_accum #(
  parameter int MAX_SAMPLES = 128,
  localparam int CW   = $clog2(MAX_SAMPLES + 1),
  localparam int SUMW = sss_pkg::SAMPLE_W + CW,
  localparam int SQW  = sss_pkg::SQ_W - 1 + CW
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sss_pkg::acc_ctl_t                   ctl,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
  output logic signed [sss_pkg::SAMPLE_W-1:0] maximum,
  output logic signed [sss_pkg::SAMPLE_W-1:0] minimum,
  output logic signed [SUMW-1:0]              sum,
  output logic        [SQW-1:0]               sum_sq,
  output logic        [CW-1:0]                cnt,
  output logic                                too_many
);

  logic                                a_valid;
  logic                                a_take;
  logic                                a_first;
  logic signed [sss_pkg::SAMPLE_W-1:0] s_a;
  logic        [sss_pkg::SQ_W-1:0]     sq_a;
  logic signed [2*sss_pkg::SAMPLE_W-1:0] prod;

  // The square never exceeds 2^30, so its low 31 bits hold it exactly.
  assign prod = sample * sample;

  // Count and overflow are settled at acceptance, so that back-to-back items
  // see the right first-sample and limit decisions.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      cnt      <= '0;
      too_many <= 1'b0;
      a_valid  <= 1'b0;
      sum      <= '0;
      sum_sq   <= '0;
    end else begin
      a_valid <= ctl.load;
      if (ctl.load) begin
        if (cnt < CW'(MAX_SAMPLES)) begin
          cnt <= cnt + 1'b1;
        end else begin
          too_many <= 1'b1;
        end
      end
      if (a_valid && a_take) begin
        sum    <= sum + SUMW'(s_a);
        sum_sq <= sum_sq + SQW'(sq_a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s_a     <= sample;
      sq_a    <= prod[sss_pkg::SQ_W-1:0];
      a_take  <= cnt < CW'(MAX_SAMPLES);
      a_first <= cnt == '0;
    end
    if (a_valid && a_take) begin
      if (a_first || s_a > maximum) begin
        maximum <= s_a;
      end
      if (a_first || s_a < minimum) begin
        minimum <= s_a;
      end
    end
  end

endmodule

/* src/sample_set_statistics.sv */
// Sample set statistics. Samples are accepted one item per cycle; the item
// that carries last closes the set, after which the block stalls its input
// while one shared compare-and-subtract unit works out the mean (one quotient
// bit a cycle), the mean square (one quotient bit a cycle) and its square
// root (one root bit a cycle). The result is held in an output register, so
// a new set may start while the previous result waits. Samples beyond
// MAX_SAMPLES are dropped and reported through too_many.
// Depends on sss_pkg, sss_accum and sss_trial_sub.
module sample_set_statistics #(
  parameter int MAX_SAMPLES = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sss_pkg::SAMPLE_W-1:0] maximum,
  output logic signed [sss_pkg::SAMPLE_W-1:0] minimum,
  output logic signed [sss_pkg::MEAN_W-1:0]   mean_q8,
  output logic        [sss_pkg::RMS_W-1:0]    rms_q8,
  output logic        [sss_pkg::COUNT_W-1:0]  sample_count,
  output logic                                too_many
);

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = sss_pkg::SAMPLE_W + CW;
  localparam int SQW  = sss_pkg::SQ_W - 1 + CW;
  localparam int MAGW = SUMW - 1;
  localparam int RW   = SQW + 16;
  localparam int RADW = RW + (RW % 2);
  localparam int RTW  = RADW / 2;
  localparam int UW   = (RTW + 2 > CW + 1) ? RTW + 2 : CW + 1;
  localparam int STW  = $clog2(RADW + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SETTLE = 7'b0000010,
    S_LOAD   = 7'b0000100,
    S_MEAN   = 7'b0001000,
    S_MSQ    = 7'b0010000,
    S_ROOT   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  sss_pkg::acc_ctl_t                   ctl;
  logic signed [sss_pkg::SAMPLE_W-1:0] acc_max;
  logic signed [sss_pkg::SAMPLE_W-1:0] acc_min;
  logic signed [SUMW-1:0]              sum;
  logic        [SQW-1:0]               sum_sq;
  logic        [CW-1:0]                cnt;
  logic                                acc_too_many;

  logic [STW-1:0]                step;
  logic [UW-1:0]                 rem;
  logic [RADW-1:0]               acc;
  logic [RTW-1:0]                root;
  logic [sss_pkg::MEAN_W-1:0]    mean_res;

  logic                          neg;
  logic signed [SUMW-1:0]        mag_full;
  logic [MAGW-1:0]               mag;
  logic [RADW-1:0]               mean_div;
  logic [RADW-1:0]               msq_div;
  logic [UW-1:0]                 unit_a;
  logic [UW-1:0]                 unit_b;
  logic [UW-1:0]                 unit_diff;
  logic                          unit_ge;
  logic [UW-1:0]                 rem_next;
  logic [RADW-1:0]               acc_div_next;
  logic [RADW-1:0]               acc_root_next;
  logic [RTW-1:0]                root_next;
  logic [sss_pkg::MEAN_W-1:0]    mean_q;
  logic [sss_pkg::MEAN_W-1:0]    mean_val;
  logic                          last_div_step;
  logic                          last_root_step;
  logic                          out_load;

  assign in_stall  = state != S_IDLE;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);
  assign ctl.load  = in_valid && !in_stall;
  assign ctl.clear = out_load;

  sss_accum #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sample  (sample),
    .maximum (acc_max),
    .minimum (acc_min),
    .sum     (sum),
    .sum_sq  (sum_sq),
    .cnt     (cnt),
    .too_many(acc_too_many)
  );

  // Mean is computed on the magnitude and the sign put back afterwards,
  // which gives truncation toward zero.
  assign neg      = sum[SUMW-1];
  assign mag_full = neg ? -sum : sum;
  assign mag      = mag_full[MAGW-1:0];
  assign mean_div = RADW'({mag, 8'd0});
  assign msq_div  = RADW'({sum_sq, 16'd0});

  // Division brings down one dividend bit a step; the root brings down two
  // and tries the divisor 4*root + 1.
  always_comb begin
    if (state == S_ROOT) begin
      unit_a = UW'({rem[RTW-1:0], acc[RADW-1 -: 2]});
      unit_b = UW'({root, 2'b01});
    end else begin
      unit_a = UW'({rem[CW-1:0], acc[RADW-1]});
      unit_b = UW'(cnt);
    end
  end

  sss_trial_sub #(
    .WIDTH(UW)
  ) u_unit (
    .minuend   (unit_a),
    .subtrahend(unit_b),
    .diff      (unit_diff),
    .ge        (unit_ge)
  );

  assign rem_next       = unit_ge ? unit_diff : unit_a;
  assign acc_div_next   = {acc[RADW-2:0], unit_ge};
  assign acc_root_next  = {acc[RADW-3:0], 2'b00};
  assign root_next      = {root[RTW-2:0], unit_ge};
  assign mean_q         = acc_div_next[sss_pkg::MEAN_W-1:0];
  assign mean_val       = neg ? sss_pkg::MEAN_W'(0) - mean_q : mean_q;
  assign last_div_step  = step == STW'(RADW - 1);
  assign last_root_step = step == STW'(RTW - 1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctl.load && last) begin
          state_next = S_SETTLE;
        end
      end
      S_SETTLE: state_next = S_LOAD;
      S_LOAD:   state_next = S_MEAN;
      S_MEAN: begin
        if (last_div_step) begin
          state_next = S_MSQ;
        end
      end
      S_MSQ: begin
        if (last_div_step) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (last_root_step) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        acc  <= mean_div;
        rem  <= '0;
        step <= '0;
      end
      S_MEAN: begin
        if (last_div_step) begin
          mean_res <= mean_val;
          acc      <= msq_div;
          rem      <= '0;
          step     <= '0;
        end else begin
          acc  <= acc_div_next;
          rem  <= rem_next;
          step <= step + 1'b1;
        end
      end
      S_MSQ: begin
        acc <= acc_div_next;
        if (last_div_step) begin
          rem  <= '0;
          root <= '0;
          step <= '0;
        end else begin
          rem  <= rem_next;
          step <= step + 1'b1;
        end
      end
      S_ROOT: begin
        acc  <= acc_root_next;
        rem  <= rem_next;
        root <= root_next;
        step <= step + 1'b1;
      end
      S_OUT: begin
        if (out_load) begin
          maximum      <= acc_max;
          minimum      <= acc_min;
          mean_q8      <= mean_res;
          rms_q8       <= root[sss_pkg::RMS_W-1:0];
          sample_count <= sss_pkg::COUNT_W'(cnt);
          too_many     <= acc_too_many;
        end
      end
      default: ;
    endcase
  end

  // A closing item must lead through the settle state into the load state.
  a_close_to_load: assert property (@(posedge clk) disable iff (rst)
    (ctl.load && last) |=> (state == S_SETTLE) ##1 (state == S_LOAD))
    else $error("closing item did not start the arithmetic");

  // The partial remainder of a division always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MEAN) || (state == S_MSQ)) |-> (rem < UW'(cnt)))
    else $error("division remainder out of range");

  // A set that reaches the result always holds at least one sample.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (cnt != '0))
    else $error("result taken with an empty set");

  // A result appears only when the sequencer hands one over.
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the hand-over state");

  // Handing over a result returns the block to accepting samples.
  a_handover: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == S_IDLE) && out_valid && (cnt == '0))
    else $error("hand-over did not clear the set");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for sample_set_statistics: streams sets of samples,
// predicts max, min, mean, RMS, count and too_many per set, and checks every
// result in order. Depends on sss_pkg and the sample_set_statistics RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLE_W = sss_pkg::SAMPLE_W;
  localparam int MEAN_W   = sss_pkg::MEAN_W;
  localparam int RMS_W    = sss_pkg::RMS_W;
  localparam int COUNT_W  = sss_pkg::COUNT_W;

  localparam int MAX_SAMPLES  = 128;
  localparam int TAIL_CYCLES  = 200;   // wait after the last set before the final check
  localparam int HOLD_CYCLES  = 600;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [MEAN_W-1:0]   mean_q8;
    logic        [RMS_W-1:0]    rms_q8;
    logic        [COUNT_W-1:0]  sample_count;
    logic                       too_many;
  } set_stats_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] maximum;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [MEAN_W-1:0]   mean_q8;
  logic        [RMS_W-1:0]    rms_q8;
  logic        [COUNT_W-1:0]  sample_count;
  logic                       too_many;

  int  idle_pct = 0;
  int  stall_pct = 0;
  logic hold_off = 1'b0;
  int  mismatches = 0;
  int  cycle_count = 0;

  set_stats_t pending_stats[$];

  // Running state of the set being predicted.
  logic signed [SAMPLE_W-1:0] run_max;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [22:0]         run_sum;
  logic        [37:0]         run_sum_sq;
  logic        [7:0]          run_count;
  logic                       run_dropped;

  sample_set_statistics #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .maximum(maximum), .minimum(minimum), .mean_q8(mean_q8), .rms_q8(rms_q8),
    .sample_count(sample_count), .too_many(too_many)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] rest;
    root = '0;
    rest = v;
    for (int b = 31; b >= 0; b--) begin
      trial = (root << (b + 1)) + (64'd1 << (2 * b));
      if (rest >= trial) begin
        rest = rest - trial;
        root = root | (64'd1 << b);
      end
    end
    return root;
  endfunction

  function automatic void clear_set();
    run_max = '0;
    run_min = '0;
    run_sum = '0;
    run_sum_sq = '0;
    run_count = '0;
    run_dropped = 1'b0;
  endfunction

  // Updates the running set with one accepted item and, on the last one,
  // queues the statistics that the block must report.
  function automatic void predict_stats(input sample_t s, input logic is_last);
    set_stats_t exp_stats;
    longint sq;
    longint sum_wide;
    longint mag;
    longint quo;
    logic [63:0] scaled_sq;
    if (run_count < MAX_SAMPLES) begin
      if (run_count == 0) begin
        run_max = s;
        run_min = s;
      end else begin
        if (s > run_max) run_max = s;
        if (s < run_min) run_min = s;
      end
      sq = s * s;
      run_sum = run_sum + s;
      run_sum_sq = run_sum_sq + sq[37:0];
      run_count = run_count + 1'b1;
    end else begin
      run_dropped = 1'b1;
    end
    if (is_last) begin
      sum_wide = run_sum;
      mag = (sum_wide < 0) ? -sum_wide : sum_wide;
      quo = (mag * 256) / run_count;
      if (sum_wide < 0) quo = -quo;
      scaled_sq = {26'd0, run_sum_sq} << 16;
      exp_stats.maximum = run_max;
      exp_stats.minimum = run_min;
      exp_stats.mean_q8 = quo[MEAN_W-1:0];
      exp_stats.rms_q8 = RMS_W'(floor_sqrt(scaled_sq / run_count));
      exp_stats.sample_count = run_count;
      exp_stats.too_many = run_dropped;
      pending_stats.push_back(exp_stats);
      clear_set();
    end
  endfunction

  function automatic void check_field(input string name, input logic [23:0] exp_v,
                                      input logic [23:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch on %s: expected %h, got %h", name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    set_stats_t exp_stats;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result with no set pending: max %h min %h", maximum, minimum);
      end else begin
        exp_stats = pending_stats.pop_front();
        check_field("maximum", 24'(exp_stats.maximum), 24'(maximum));
        check_field("minimum", 24'(exp_stats.minimum), 24'(minimum));
        check_field("mean_q8", exp_stats.mean_q8, mean_q8);
        check_field("rms_q8", exp_stats.rms_q8, rms_q8);
        check_field("sample_count", 24'(exp_stats.sample_count), 24'(sample_count));
        check_field("too_many", 24'(exp_stats.too_many), 24'(too_many));
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance, with valid still high.
  task automatic send_item(input sample_t s, input logic is_last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    last <= is_last;
    do @(posedge clk); while (in_stall);
    predict_stats(s, is_last);
    @(negedge clk);
  endtask

  task automatic send_set(input sample_t vals[$]);
    for (int i = 0; i < vals.size(); i++)
      send_item(vals[i], i == vals.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
  endtask

  function automatic sample_t random_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return S_MAX;
    if (pick < 8) return S_MIN;
    if (pick < 10) return '0;
    if (pick < 12) return -16'sd1;
    return sample_t'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic int random_set_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(1, 8);
    if (pick < 97) return $urandom_range(9, MAX_SAMPLES - 1);
    return $urandom_range(MAX_SAMPLES, MAX_SAMPLES + 6);
  endfunction

  function automatic void fill_random(ref sample_t vals[$], input int len);
    vals.delete();
    for (int i = 0; i < len; i++) vals.push_back(random_sample());
  endfunction

  task automatic test_extremes();
    sample_t vals[$];
    idle_pct = 0;
    stall_pct = 0;
    vals = '{S_MAX};              send_set(vals);
    vals = '{S_MIN};              send_set(vals);
    vals = '{16'sd0};             send_set(vals);
    vals = '{-16'sd1};            send_set(vals);
    vals = '{S_MAX, S_MIN};       send_set(vals);
    vals = '{16'sd1, 16'sd2};     send_set(vals);
    // The mean of this set is not whole and must be cut toward zero.
    vals = '{-16'sd3, -16'sd3, -16'sd2}; send_set(vals);
    vals = '{16'sd5, -16'sd7, 16'sd0, S_MAX, S_MIN, 16'sd1}; send_set(vals);
    vals = '{16'sd2, 16'sd3, 16'sd5, 16'sd7}; send_set(vals);
    wait_drained();
  endtask

  task automatic test_full_sets();
    sample_t vals[$];
    idle_pct = 10;
    stall_pct = 10;
    vals.delete();
    for (int i = 0; i < MAX_SAMPLES; i++) vals.push_back(S_MIN);
    send_set(vals);
    // Three items too many, the one carrying last among those dropped.
    fill_random(vals, MAX_SAMPLES + 3);
    send_set(vals);
    wait_drained();
  endtask

  task automatic test_random_sets(input int n_items, input int idle, input int stall);
    sample_t vals[$];
    int sent;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      fill_random(vals, random_set_len());
      send_set(vals);
      sent += vals.size();
    end
    wait_drained();
  endtask

  // The receiver holds off while short sets keep coming, so the output
  // register fills and the block has to stall its input.
  task automatic test_backpressure();
    sample_t vals[$];
    int sent;
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    sent = 0;
    while (sent < 40) begin
      fill_random(vals, $urandom_range(1, 3));
      send_set(vals);
      sent += vals.size();
    end
    wait_drained();
  endtask

  initial begin
    clear_set();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_full_sets();
    test_random_sets(80, 0, 0);
    test_random_sets(80, 48, 0);
    test_random_sets(80, 0, 48);
    test_random_sets(80, 27, 27);
    test_backpressure();
    test_random_sets(40, 0, 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
